>>> hw/rtl/esc_pkg.sv
package esc_pkg;

  // Field widths
  localparam int unsigned EpochW  = 32;
  localparam int unsigned OffsetW = 5;
  localparam int unsigned YearW   = 12;
  localparam int unsigned MonthW  = 4;
  localparam int unsigned DayW    = 5;
  localparam int unsigned HourW   = 5;
  localparam int unsigned MinuteW = 6;
  localparam int unsigned SecondW = 6;

  // Internal widths: days since epoch and seconds of day
  localparam int unsigned DaysW   = 16;
  localparam int unsigned SodW    = 17;

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic        RegUtcOffset = 1'b0;   // register index, paddr[2]
  localparam logic signed [OffsetW-1:0] OffsetReset = 5'sd8;

  // Day split handed from the front end to the calendar stages
  typedef struct packed {
    logic [DaysW-1:0] days;
    logic [SodW-1:0]  secs;
  } esc_split_t;

endpackage

>>> hw/rtl/esc_apb_regs.sv
module esc_apb_regs import esc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CfgAddrW-1:0]        paddr,
  input  logic [CfgDataW-1:0]        pwdata,
  output logic [CfgDataW-1:0]        prdata,
  output logic                       pready,
  output logic signed [OffsetW-1:0]  offset_o
);

  logic signed [OffsetW-1:0] offset_d, offset_q;
  logic                      hit;

  // Word index lives in paddr[2]; byte lanes are ignored
  assign hit    = (paddr[2] == RegUtcOffset);
  assign pready = 1'b1;

  // Write on the access phase
  always_comb begin
    offset_d = offset_q;
    if (psel && penable && pwrite && hit) begin
      offset_d = pwdata[OffsetW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else begin
      offset_q <= offset_d;
    end
  end

  // Read back, zero-extended
  assign prdata   = hit ? {{(CfgDataW-OffsetW){1'b0}}, offset_q} : '0;
  assign offset_o = offset_q;

endmodule

>>> hw/rtl/esc_day_split.sv
module esc_day_split import esc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  logic [EpochW-1:0]          epoch_i,
  input  logic signed [OffsetW-1:0]  offset_i,
  output logic                       valid_o,
  output esc_split_t                 split_o
);

  // t / 86400 = (t >> 7) / 675, reciprocal exact for 26-bit dividends
  localparam logic [26:0] Rcp675   = 27'd101806633;
  localparam int unsigned Shift675 = 36;
  localparam logic [9:0]  Div675   = 10'd675;
  localparam logic signed [13:0] SecsPerHour = 14'sd3600;

  // Stage 1: local seconds, clamped at zero
  logic signed [18:0] off_secs;
  logic signed [33:0] local_s;
  logic [32:0]        t_d, t_q;
  logic               v1_q;

  assign off_secs = offset_i * SecsPerHour;
  assign local_s  = $signed({2'b00, epoch_i}) + {{15{off_secs[18]}}, off_secs};
  assign t_d      = local_s[33] ? '0 : local_s[32:0];

  // Stage 2: day count by reciprocal multiply
  logic [52:0]      prod675;
  logic [DaysW-1:0] days_d, days_q;
  logic [25:0]      x_q;
  logic [6:0]       lo7_q;
  logic             v2_q;

  assign prod675 = t_q[32:7] * Rcp675;
  assign days_d  = prod675[Shift675+DaysW-1:Shift675];

  // Stage 3: seconds of day from the remainder
  logic [25:0]     rem675;
  logic [SodW-1:0] secs_d;
  esc_split_t      split_q;
  logic            v3_q;

  assign rem675 = x_q - 26'(days_q * Div675);
  assign secs_d = {rem675[9:0], lo7_q};

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    t_q          <= t_d;
    days_q       <= days_d;
    x_q          <= t_q[32:7];
    lo7_q        <= t_q[6:0];
    split_q.days <= days_q;
    split_q.secs <= secs_d;
  end

  assign valid_o = v3_q;
  assign split_o = split_q;

endmodule

>>> hw/rtl/esc_calendar.sv
module esc_calendar import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  esc_split_t         split_i,
  output logic               valid_o,
  output logic [YearW-1:0]   year_o,
  output logic [MonthW-1:0]  month_o,
  output logic [DayW-1:0]    day_o,
  output logic [HourW-1:0]   hour_o,
  output logic [MinuteW-1:0] minute_o,
  output logic [SecondW-1:0] second_o
);

  // Reciprocals, each exact over its operand range
  localparam logic [16:0] Rcp1461   = 17'd91868;   // days / 1461, >> 27
  localparam int unsigned Sh1461    = 27;
  localparam logic [17:0] Rcp60Sec  = 18'd139811;  // secs / 60, >> 23
  localparam int unsigned Sh60Sec   = 23;
  localparam logic [11:0] Rcp60Min  = 12'd2185;    // mins / 60, >> 17
  localparam int unsigned Sh60Min   = 17;
  localparam logic [10:0] DaysCycle = 11'd1461;
  localparam logic [5:0]  Sixty     = 6'd60;
  localparam logic [10:0] Year1End  = 11'd365;
  localparam logic [10:0] Year2End  = 11'd730;
  localparam logic [10:0] Year3End  = 11'd1096;
  localparam logic [YearW-1:0] BaseYear = 12'd1970;

  // First day of each month, common year
  localparam logic [8:0] MonthStart [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

  // ---------------- Stage 1: cycle index and total minutes
  logic [32:0]      cyc_prod;
  logic [34:0]      min_prod;
  logic [5:0]       c1_cyc_q;
  logic [10:0]      c1_mins_q;
  logic [DaysW-1:0] c1_days_q;
  logic [SodW-1:0]  c1_secs_q;
  logic             v1_q;

  assign cyc_prod = split_i.days * Rcp1461;
  assign min_prod = split_i.secs * Rcp60Sec;

  // ---------------- Stage 2: day of cycle, second, hour
  logic [DaysW-1:0]   drem_full;
  logic [SodW-1:0]    sec_full;
  logic [22:0]        hour_prod;
  logic [5:0]         c2_cyc_q;
  logic [10:0]        c2_drem_q;
  logic [10:0]        c2_mins_q;
  logic [HourW-1:0]   c2_hour_q;
  logic [SecondW-1:0] c2_sec_q;
  logic               v2_q;

  assign drem_full = c1_days_q - 16'(c1_cyc_q * DaysCycle);
  assign sec_full  = c1_secs_q - 17'(c1_mins_q * Sixty);
  assign hour_prod = c1_mins_q * Rcp60Min;

  // ---------------- Stage 3: year, day of year, minute
  logic [1:0]         yy;
  logic [10:0]        doy_full;
  logic               leap_d;
  logic [YearW-1:0]   year_d;
  logic [10:0]        min_full;
  logic [YearW-1:0]   c3_year_q;
  logic [8:0]         c3_doy_q;
  logic               c3_leap_q;
  logic [HourW-1:0]   c3_hour_q;
  logic [MinuteW-1:0] c3_min_q;
  logic [SecondW-1:0] c3_sec_q;
  logic               v3_q;

  // Leap year is the third of each four-year cycle
  always_comb begin
    priority if (c2_drem_q < Year1End) begin
      yy       = 2'd0;
      doy_full = c2_drem_q;
      leap_d   = 1'b0;
    end else if (c2_drem_q < Year2End) begin
      yy       = 2'd1;
      doy_full = c2_drem_q - Year1End;
      leap_d   = 1'b0;
    end else if (c2_drem_q < Year3End) begin
      yy       = 2'd2;
      doy_full = c2_drem_q - Year2End;
      leap_d   = 1'b1;
    end else begin
      yy       = 2'd3;
      doy_full = c2_drem_q - Year3End;
      leap_d   = 1'b0;
    end
  end

  assign year_d   = BaseYear + {4'd0, c2_cyc_q, 2'b00} + {10'd0, yy};
  assign min_full = c2_mins_q - 11'(c2_hour_q * Sixty);

  // ---------------- Stage 4: month and day of month
  logic [MonthW-1:0] month_d;
  logic [8:0]        base_d;
  logic [8:0]        start_m;
  logic [8:0]        day_full;

  always_comb begin
    month_d = 4'd1;
    base_d  = MonthStart[0];
    start_m = '0;
    for (int m = 1; m < 12; m++) begin
      start_m = MonthStart[m] + {8'd0, c3_leap_q && (m >= 2)};
      if (c3_doy_q >= start_m) begin
        month_d = 4'(m + 1);
        base_d  = start_m;
      end
    end
  end

  assign day_full = c3_doy_q - base_d + 9'd1;

  logic v4_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    c1_cyc_q  <= cyc_prod[Sh1461+5:Sh1461];
    c1_mins_q <= min_prod[Sh60Sec+10:Sh60Sec];
    c1_days_q <= split_i.days;
    c1_secs_q <= split_i.secs;

    c2_cyc_q  <= c1_cyc_q;
    c2_drem_q <= drem_full[10:0];
    c2_mins_q <= c1_mins_q;
    c2_hour_q <= hour_prod[Sh60Min+HourW-1:Sh60Min];
    c2_sec_q  <= sec_full[SecondW-1:0];

    c3_year_q <= year_d;
    c3_doy_q  <= doy_full[8:0];
    c3_leap_q <= leap_d;
    c3_hour_q <= c2_hour_q;
    c3_min_q  <= min_full[MinuteW-1:0];
    c3_sec_q  <= c2_sec_q;

    year_o    <= c3_year_q;
    month_o   <= month_d;
    day_o     <= day_full[DayW-1:0];
    hour_o    <= c3_hour_q;
    minute_o  <= c3_min_q;
    second_o  <= c3_sec_q;
  end

  assign valid_o = v4_q;

endmodule

>>> hw/rtl/epoch_seconds_to_calendar.sv
// Channel   Ports                                   Transfer
// -------   -------------------------------------   -----------------------------------
// request   start_i, busy_o, epoch_seconds_i        taken when start_i && !busy_o
// result    valid_o, year_o .. second_o             one cycle, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata,   APB write on access phase
//           prdata, pready                          (utc_offset_hours at address 0)
//
// One request per cycle; each result passes through the seven register stages
// (three for the day split, four calendar).
// busy_o stays low: the pipeline never stalls since results cannot be held.
// Reset clears the valid bits and loads an offset of +8 hours.
module epoch_seconds_to_calendar import esc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic [EpochW-1:0]    epoch_seconds_i,
  output logic                 valid_o,
  output logic [YearW-1:0]     year_o,
  output logic [MonthW-1:0]    month_o,
  output logic [DayW-1:0]      day_o,
  output logic [HourW-1:0]     hour_o,
  output logic [MinuteW-1:0]   minute_o,
  output logic [SecondW-1:0]   second_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CfgAddrW-1:0]  paddr,
  input  logic [CfgDataW-1:0]  pwdata,
  output logic [CfgDataW-1:0]  prdata,
  output logic                 pready
);

  logic signed [OffsetW-1:0] offset;
  logic                      split_valid;
  esc_split_t                split;
  logic                      req_take;

  assign busy_o   = 1'b0;
  assign req_take = start_i && !busy_o;

  // Offset register
  esc_apb_regs u_regs (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .offset_o (offset)
  );

  // Local seconds to days and seconds of day
  esc_day_split u_split (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (req_take),
    .epoch_i  (epoch_seconds_i),
    .offset_i (offset),
    .valid_o  (split_valid),
    .split_o  (split)
  );

  // Days and seconds to calendar fields
  esc_calendar u_cal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (split_valid),
    .split_i  (split),
    .valid_o  (valid_o),
    .year_o   (year_o),
    .month_o  (month_o),
    .day_o    (day_o),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

endmodule
